/* hw/rtl/loc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Level occupancy calculator package
// Shared constants and size helpers for the level cells.
// ---------------------------------------------------------------------------
package loc_pkg;

    localparam int unsigned NumLevelsDef = 11;
    localparam int unsigned WalkLimit    = 6;
    localparam logic [31:0] AllOnes      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] seq;
        logic [3:0]  lvl;
        logic [31:0] below;
        logic [31:0] cs;
        logic [31:0] ss;
    } t_cell_data;

    // Mask of level size minus one: 4^(l+1) - 1.
    function automatic logic [31:0] size_mask(input logic [3:0] l);
        logic [33:0] s;
        s = 34'd1 << ({1'b0, l, 1'b0} + 6'd2);
        return s[31:0] - 32'd1;
    endfunction

    // Mask of level half minus one: 2*4^l - 1.
    function automatic logic [31:0] half_mask(input logic [3:0] l);
        logic [33:0] s;
        s = 34'd1 << ({1'b0, l, 1'b0} + 6'd1);
        return s[31:0] - 32'd1;
    endfunction

endpackage : loc_pkg
`default_nettype wire

/* hw/rtl/loc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Level cell
// Works out one level's bucket sizes, with a bounded step-back walk on the
// middle levels, then hands the running lower-level sum to the next cell.
// ---------------------------------------------------------------------------
module loc_cell
    import loc_pkg::*;
#(
    parameter logic [3:0] CellLevel = 4'd0,
    parameter logic [3:0] LastLevel = 4'd10
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_go,
    input  wire t_cell_data  i_data,
    output logic             o_go,
    output t_cell_data       o_data
);

    localparam logic [31:0] HalfM  = half_mask(CellLevel);
    localparam logic [31:0] SizeM  = size_mask(CellLevel);
    localparam logic [31:0] PHalfM = (CellLevel == 4'd0) ? 32'd0 : half_mask(CellLevel - 4'd1);
    localparam logic [31:0] PSizeM = (CellLevel == 4'd0) ? 32'd0 : size_mask(CellLevel - 4'd1);
    localparam logic [31:0] Delta  = (CellLevel == 4'd0) ? 32'd0 : PHalfM + 32'd1;
    localparam bit          UseWalk = (CellLevel != 4'd0) && (CellLevel != LastLevel);

    t_cell_data  r_data, n_data;
    logic        r_busy, n_busy;
    logic        r_out, n_out;
    logic [2:0]  r_step, n_step;
    logic [31:0] r_x, n_x;
    logic [31:0] r_acc, n_acc;
    logic [31:0] v_cs, v_ss, v_below;
    logic        v_hit, v_pal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_out  <= n_out;
        end
        r_data <= n_data;
        r_step <= n_step;
        r_x    <= n_x;
        r_acc  <= n_acc;
    end

    always_comb begin
        n_busy = r_busy;
        n_out  = 1'b0;
        n_data = r_data;
        n_step = r_step;
        n_x    = r_x;
        n_acc  = r_acc;
        v_hit  = ((r_x & HalfM) == 32'd0) || ((r_x & SizeM) == 32'd0);
        v_pal  = ((r_x & PHalfM) == 32'd0) || ((r_x & PSizeM) == 32'd0);
        v_cs   = 32'd0;
        v_ss   = 32'd0;
        v_below = 32'd0;
        if (i_go && (i_data.lvl >= CellLevel)) begin
            n_data = i_data;
            n_busy = 1'b1;
            n_step = 3'd0;
            n_x    = i_data.seq;
            n_acc  = 32'd0;
        end else if (i_go) begin
            n_data = i_data;
            n_out  = 1'b1;
        end else if (r_busy) begin
            if (!UseWalk || ((r_data.seq & ~HalfM) == 32'd0) ||
                    v_hit || (r_step == 3'(WalkLimit))) begin
                if (CellLevel == 4'd0)
                    v_cs = (r_data.seq == 32'd1) ? 32'd1 : 32'd1 + {31'd0, r_data.seq[0]};
                else if (UseWalk && ((r_data.seq & ~HalfM) != 32'd0))
                    v_cs = v_hit && (r_step != 3'(WalkLimit)) ? r_acc + Delta : r_acc;
                else
                    v_cs = r_data.seq - r_data.below;
                if (CellLevel == LastLevel)
                    v_ss = 32'd0;
                else if ((r_data.seq & ~SizeM) != 32'd0)
                    v_ss = HalfM + 32'd1;
                else
                    v_ss = r_data.seq - r_data.below - v_cs;
                if (r_data.lvl == CellLevel)
                    v_below = r_data.below;
                else
                    v_below = r_data.below + v_cs + v_ss;
                n_data.cs    = v_cs;
                n_data.ss    = v_ss;
                n_data.below = v_below;
                n_busy = 1'b0;
                n_out  = 1'b1;
            end else begin
                if (v_pal)
                    n_acc = r_acc + Delta;
                n_x    = (r_x - 32'd1) & ~PHalfM;
                n_step = r_step + 3'd1;
            end
        end
    end

    assign o_go   = r_out;
    assign o_data = r_data;

endmodule : loc_cell
`default_nettype wire

/* hw/rtl/level_occupancy_calculator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Level occupancy calculator
// Reports bucket sizes, oldest numbers and spill for one level of a
// geometric multi-level merge list.
//
//   Channel   Direction  Handshake           Payload
//   request   in         i_start, o_busy     i_seq_number, i_level_index
//   result    out        o_done (strobe)     o_curr_size .. o_bad_request
//
// A request passes through one cell per level; a cell above the requested
// level only registers it, the others work out their sizes, the middle levels
// with a bounded step-back walk, before passing it on. A bad request is
// answered in the cycle after acceptance. Reset is synchronous and clears all
// control state. The receiver cannot stall; for a valid request o_busy is high
// from acceptance until the result strobe.
// ---------------------------------------------------------------------------
module level_occupancy_calculator_unit
    import loc_pkg::*;
#(
    parameter int unsigned NUM_LEVELS = NumLevelsDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [31:0] i_seq_number,
    input  wire  [3:0]  i_level_index,
    output logic        o_done,
    output logic [31:0] o_curr_size,
    output logic [31:0] o_snap_size,
    output logic [31:0] o_oldest_curr,
    output logic [31:0] o_oldest_snap,
    output logic        o_spills,
    output logic        o_bad_request
);

    localparam logic [3:0] Last = 4'(NUM_LEVELS - 1);

    logic       r_busy;
    logic       r_done;
    logic [31:0] r_cs, r_ss, r_oc, r_os;
    logic       r_sp, r_bad;
    logic       v_go  [NUM_LEVELS+1];
    t_cell_data v_dat [NUM_LEVELS+1];
    logic       v_bad;
    t_cell_data v_fin;
    logic [31:0] v_rem;

    assign v_bad = (i_seq_number == 32'd0) || (32'(i_level_index) >= NUM_LEVELS);
    assign v_go[0] = i_start && !r_busy && !v_bad;
    always_comb begin
        v_dat[0]       = '0;
        v_dat[0].seq   = i_seq_number;
        v_dat[0].lvl   = i_level_index;
    end

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cell
        loc_cell #(.CellLevel(4'(g)), .LastLevel(Last)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_go   (v_go[g]),
            .i_data (v_dat[g]),
            .o_go   (v_go[g+1]),
            .o_data (v_dat[g+1])
        );
    end

    assign v_fin = v_dat[NUM_LEVELS];
    assign v_rem = v_fin.seq - v_fin.below - v_fin.cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= (i_start && !r_busy && v_bad) || v_go[NUM_LEVELS];
            if (v_go[NUM_LEVELS])
                r_busy <= 1'b0;
            else if (i_start && !r_busy && !v_bad)
                r_busy <= 1'b1;
        end
        if (i_start && !r_busy && v_bad) begin
            r_cs <= '0; r_ss <= '0; r_oc <= '0; r_os <= '0;
            r_sp <= 1'b0; r_bad <= 1'b1;
        end else if (v_go[NUM_LEVELS]) begin
            r_cs  <= v_fin.cs;
            r_ss  <= v_fin.ss;
            r_oc  <= (v_fin.cs == 32'd0) ? AllOnes : v_rem + 32'd1;
            r_os  <= (v_fin.ss == 32'd0) ? AllOnes : v_rem - v_fin.ss + 32'd1;
            r_sp  <= (v_fin.lvl != Last) &&
                     (((v_fin.seq & half_mask(v_fin.lvl)) == 32'd0) ||
                      ((v_fin.seq & size_mask(v_fin.lvl)) == 32'd0));
            r_bad <= 1'b0;
        end
    end

    assign o_busy        = r_busy;
    assign o_done        = r_done;
    assign o_curr_size   = r_cs;
    assign o_snap_size   = r_ss;
    assign o_oldest_curr = r_oc;
    assign o_oldest_snap = r_os;
    assign o_spills      = r_sp;
    assign o_bad_request = r_bad;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result while busy");
    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_seq_number == 32'd0) |=> (o_done && o_bad_request))
        else $error("bad request not flagged");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !v_bad) |=> o_busy) else $error("busy missing");

endmodule : level_occupancy_calculator_unit
`default_nettype wire

/* verif/level_occupancy_calculator_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Level occupancy calculator testbench
// Drives directed and random queries, predicts each result in the bench and
// compares every strobed result field by field in order of issue.
// ---------------------------------------------------------------------------
module level_occupancy_calculator_unit_tb;
    import loc_pkg::*;

    localparam int unsigned LEVELS = NumLevelsDef;
    localparam int unsigned STEP_BACK_MAX = 6;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [31:0] seq;
        logic [3:0]  lvl;
    } query_t;

    typedef struct packed {
        logic [31:0] curr_size;
        logic [31:0] snap_size;
        logic [31:0] oldest_curr;
        logic [31:0] oldest_snap;
        logic        spills;
        logic        bad_request;
    } occupancy_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [31:0] i_seq_number = '0;
    logic [3:0]  i_level_index = '0;
    logic        o_busy, o_done, o_spills, o_bad_request;
    logic [31:0] o_curr_size, o_snap_size, o_oldest_curr, o_oldest_snap;

    query_t     pending_queries[$];
    occupancy_t expected_occupancy[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_percent = 9;
    int unsigned sent_count = 0;
    bit          stimulus_done = 1'b0;

    level_occupancy_calculator_unit uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] level_span(input int unsigned l);
        return 32'd1 << (2 * (l + 1));
    endfunction

    function automatic logic is_multiple(input logic [31:0] v, input logic [31:0] m);
        return (v & (m - 32'd1)) == 32'd0;
    endfunction

    function automatic logic [31:0] step_back_size(input logic [31:0] n, input int unsigned l);
        logic [31:0] span, half, pspan, phalf, delta, acc, x, prev;
        span = level_span(l);
        half = span >> 1;
        pspan = level_span(l - 1);
        phalf = pspan >> 1;
        delta = 32'd1 << (2 * l - 1);
        acc = '0;
        x = n;
        for (int i = 0; i < STEP_BACK_MAX; i++) begin
            if (is_multiple(x, half) || is_multiple(x, span))
                return acc + delta;
            prev = (x - 32'd1) & ~(phalf - 32'd1);
            if (is_multiple(x, phalf) || is_multiple(x, pspan))
                acc += delta;
            x = prev;
        end
        return acc;
    endfunction

    function automatic occupancy_t predict_occupancy(input query_t q);
        occupancy_t r;
        logic [31:0] below, cs, ss, n;
        int unsigned last;
        r = '0;
        n = q.seq;
        last = LEVELS - 1;
        below = '0;
        cs = '0;
        ss = '0;
        if (n == 0 || q.lvl >= LEVELS) begin
            r.bad_request = 1'b1;
            return r;
        end
        for (int unsigned l = 0; l <= q.lvl; l++) begin
            if (l == 0)
                cs = (n == 1) ? 32'd1 : 32'd1 + {31'd0, n[0]};
            else if (l != last && (n & ~((level_span(l) >> 1) - 32'd1)) != 0)
                cs = step_back_size(n, l);
            else
                cs = n - below;
            if (l == last)
                ss = '0;
            else if ((n & ~(level_span(l) - 32'd1)) != 0)
                ss = level_span(l) >> 1;
            else
                ss = n - below - cs;
            if (l < q.lvl)
                below += cs + ss;
        end
        r.curr_size = cs;
        r.snap_size = ss;
        r.oldest_curr = (cs == 0) ? AllOnes : n - below - cs + 32'd1;
        r.oldest_snap = (ss == 0) ? AllOnes : n - below - cs - ss + 32'd1;
        r.spills = (q.lvl != last) && (is_multiple(n, level_span(q.lvl) >> 1)
                   || is_multiple(n, level_span(q.lvl)));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic add_query(input logic [31:0] seq, input logic [3:0] lvl);
        query_t q;
        q.seq = seq;
        q.lvl = lvl;
        pending_queries.insert(pending_queries.size(), q);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                expected_occupancy.insert(expected_occupancy.size(),
                    predict_occupancy('{seq: i_seq_number, lvl: i_level_index}));
            end
            if ((!i_start || !o_busy) && pending_queries.size() > 0
                && $urandom_range(99) >= idle_percent) begin
                query_t q;
                q = pending_queries.pop_front();
                sent_count++;
                if (sent_count == 320)
                    idle_percent = 85;
                if (sent_count == 640)
                    idle_percent = 0;
                i_start <= 1'b1;
                i_seq_number <= q.seq;
                i_level_index <= q.lvl;
            end else if (!i_start || !o_busy) begin
                i_start <= 1'b0;
                i_seq_number <= $urandom;
                i_level_index <= 4'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_occupancy.size() == 0) begin
                report_mismatch("unexpected result", {31'd0, o_done}, 32'd0);
            end else begin
                occupancy_t e;
                e = expected_occupancy.pop_front();
                if (o_curr_size !== e.curr_size)
                    report_mismatch("curr_size", o_curr_size, e.curr_size);
                if (o_snap_size !== e.snap_size)
                    report_mismatch("snap_size", o_snap_size, e.snap_size);
                if (o_oldest_curr !== e.oldest_curr)
                    report_mismatch("oldest_curr", o_oldest_curr, e.oldest_curr);
                if (o_oldest_snap !== e.oldest_snap)
                    report_mismatch("oldest_snap", o_oldest_snap, e.oldest_snap);
                if (o_spills !== e.spills)
                    report_mismatch("spills", {31'd0, o_spills}, {31'd0, e.spills});
                if (o_bad_request !== e.bad_request)
                    report_mismatch("bad_request", {31'd0, o_bad_request},
                                    {31'd0, e.bad_request});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] random_seq();
        case ($urandom_range(5))
            0: return $urandom_range(1, 300);
            1: return 32'd1 << $urandom_range(31);
            2: return (32'd1 << $urandom_range(31)) + $urandom_range(3) - 1;
            3: return $urandom & ~((32'd1 << $urandom_range(20)) - 32'd1);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        query_t q;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        add_query(32'd0, 4'd0);
        add_query(32'd5, 4'd11);
        add_query(32'd0, 4'd15);
        add_query(32'hFFFF_FFFF, 4'd15);
        add_query(32'd1, 4'd0);
        add_query(32'd2, 4'd0);
        add_query(32'd3, 4'd1);
        add_query(32'd8, 4'd1);
        add_query(32'd16, 4'd1);
        add_query(32'd32, 4'd2);
        add_query(32'd1, 4'd10);
        add_query(32'hFFFF_FFFF, 4'd10);
        add_query(32'hFFFF_FFFF, 4'd9);
        add_query(32'h8000_0000, 4'd10);
        add_query(32'h0020_0000, 4'd9);
        add_query(32'h0010_0000, 4'd9);
        add_query(32'd100, 4'd3);
        add_query(32'd1000, 4'd5);
        for (int i = 0; i < 950; i++) begin
            q.seq = random_seq();
            q.lvl = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(LEVELS - 1));
            add_query(q.seq, q.lvl);
        end
        wait (pending_queries.size() == 0);
        @(posedge i_clk);
        wait (!o_busy && expected_occupancy.size() == 0);
        repeat (120) @(posedge i_clk);
        if (error_count == 0 && expected_occupancy.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
